[rtl/dchf_pkg.sv]
package dchf_pkg;

  localparam int unsigned RunW  = 16;
  localparam int unsigned MissW = 9;
  localparam int unsigned CfgW  = 8;

  localparam logic [RunW-1:0]  RUN_MAX  = '1;
  localparam logic [MissW-1:0] MISS_MAX = '1;

  // detector status codes on the input
  typedef enum logic [1:0] {
    FRM_RUNNING  = 2'd0,
    FRM_DISABLED = 2'd1,
    FRM_ERROR    = 2'd2,
    FRM_UNUSED   = 2'd3
  } frame_status_t;

  // reported tracking status
  typedef enum logic [2:0] {
    TRK_IDLE      = 3'd0,
    TRK_CANDIDATE = 3'd1,
    TRK_CONFIRMED = 3'd2,
    TRK_DISABLED  = 3'd3,
    TRK_ERROR     = 3'd4
  } track_status_t;

  // configuration register indexes
  typedef enum logic [0:0] {
    CFG_FRAMES_TO_CONFIRM = 1'b0,
    CFG_HOLDOVER_FRAMES   = 1'b1
  } cfg_index_t;

  typedef struct packed {
    logic [1:0]  frame_status;
    logic        has_detection;
    logic [7:0]  sign_code;
    logic [7:0]  label_code;
    logic [31:0] frame_time_ms;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  track_status;
    logic [7:0]  tracked_sign;
    logic [7:0]  tracked_label;
    logic [15:0] run_length;
    logic [7:0]  needed_frames;
    logic [31:0] confirm_time_ms;
    logic [31:0] seen_time_ms;
  } out_item_t;

  typedef struct packed {
    logic [CfgW-1:0] frames_to_confirm;
    logic [CfgW-1:0] holdover_frames;
  } cfg_t;

endpackage

[rtl/dchf_slot.sv]
module dchf_slot (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                advance,
  input  dchf_pkg::in_item_t  item,
  input  dchf_pkg::cfg_t      cfg,
  output dchf_pkg::out_item_t result
);

  logic                        valid_r, valid_nxt;
  logic                        conf_r, conf_nxt;
  logic [7:0]                  sign_r, sign_nxt;
  logic [7:0]                  label_r, label_nxt;
  logic [dchf_pkg::RunW-1:0]   run_r, run_nxt;
  logic [31:0]                 ctime_r, ctime_nxt;
  logic [31:0]                 stime_r, stime_nxt;
  logic [dchf_pkg::MissW-1:0]  miss_r, miss_nxt;

  logic [dchf_pkg::MissW-1:0]  miss_inc;
  logic [dchf_pkg::RunW-1:0]   run_inc;
  logic [dchf_pkg::RunW-1:0]   ftc_ext;
  logic                        same;
  logic                        show;
  dchf_pkg::track_status_t     status;

  assign miss_inc = (miss_r == dchf_pkg::MISS_MAX) ? miss_r : miss_r + 1'b1;
  assign run_inc  = (run_r == dchf_pkg::RUN_MAX) ? run_r : run_r + 1'b1;
  assign ftc_ext  = {{(dchf_pkg::RunW-dchf_pkg::CfgW){1'b0}}, cfg.frames_to_confirm};
  assign same     = valid_r && (sign_r == item.sign_code) && (label_r == item.label_code);

  always_comb begin
    valid_nxt = valid_r;
    conf_nxt  = conf_r;
    sign_nxt  = sign_r;
    label_nxt = label_r;
    run_nxt   = run_r;
    ctime_nxt = ctime_r;
    stime_nxt = stime_r;
    miss_nxt  = miss_r;
    status    = dchf_pkg::TRK_IDLE;
    show      = 1'b0;

    if (dchf_pkg::frame_status_t'(item.frame_status) != dchf_pkg::FRM_RUNNING) begin
      valid_nxt = 1'b0;
      conf_nxt  = 1'b0;
      miss_nxt  = '0;
      status    = (dchf_pkg::frame_status_t'(item.frame_status) == dchf_pkg::FRM_DISABLED)
                  ? dchf_pkg::TRK_DISABLED : dchf_pkg::TRK_ERROR;
    end else if (!item.has_detection) begin
      // holdover: keep reporting the slot while misses stay within the limit
      if (valid_r && (miss_inc <= {1'b0, cfg.holdover_frames})) begin
        miss_nxt = miss_inc;
        show     = 1'b1;
        status   = conf_r ? dchf_pkg::TRK_CONFIRMED : dchf_pkg::TRK_CANDIDATE;
      end else begin
        valid_nxt = 1'b0;
        conf_nxt  = 1'b0;
        miss_nxt  = '0;
      end
    end else begin
      miss_nxt = '0;
      show     = 1'b1;
      if (same && conf_r) begin
        run_nxt   = (run_inc < ftc_ext) ? ftc_ext : run_inc;
        stime_nxt = item.frame_time_ms;
        status    = dchf_pkg::TRK_CONFIRMED;
      end else if (same) begin
        run_nxt   = run_inc;
        stime_nxt = item.frame_time_ms;
        if (run_inc >= ftc_ext) begin
          conf_nxt  = 1'b1;
          ctime_nxt = item.frame_time_ms;
          status    = dchf_pkg::TRK_CONFIRMED;
        end else begin
          status = dchf_pkg::TRK_CANDIDATE;
        end
      end else begin
        // a new sign or label, or an empty slot, restarts the slot
        valid_nxt = 1'b1;
        sign_nxt  = item.sign_code;
        label_nxt = item.label_code;
        stime_nxt = item.frame_time_ms;
        if (cfg.frames_to_confirm <= 8'd1) begin
          conf_nxt  = 1'b1;
          run_nxt   = ftc_ext;
          ctime_nxt = item.frame_time_ms;
          status    = dchf_pkg::TRK_CONFIRMED;
        end else begin
          conf_nxt = 1'b0;
          run_nxt  = {{(dchf_pkg::RunW-1){1'b0}}, 1'b1};
          status   = dchf_pkg::TRK_CANDIDATE;
        end
      end
    end
  end

  always_comb begin
    result.track_status    = status;
    result.tracked_sign    = show ? sign_nxt : '0;
    result.tracked_label   = show ? label_nxt : '0;
    result.run_length      = show ? run_nxt : '0;
    result.needed_frames   = cfg.frames_to_confirm;
    result.confirm_time_ms = (show && conf_nxt) ? ctime_nxt : '0;
    result.seen_time_ms    = show ? stime_nxt : '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      conf_r  <= 1'b0;
      miss_r  <= '0;
    end else if (advance) begin
      valid_r <= valid_nxt;
      conf_r  <= conf_nxt;
      miss_r  <= miss_nxt;
    end
  end

  // slot payload is only looked at while valid_r is set
  always_ff @(posedge clk) begin
    if (advance) begin
      sign_r  <= sign_nxt;
      label_r <= label_nxt;
      run_r   <= run_nxt;
      ctime_r <= ctime_nxt;
      stime_r <= stime_nxt;
    end
  end

endmodule

[rtl/detection_confirm_holdover_filter.sv]
// Confirms a detected sign over consecutive frames and holds it through short
// gaps. Each input request is one detector frame and yields exactly one result
// request. A request is captured in an input register, evaluated against the
// single tracked slot, and written to the output register, which raises
// out_valid; a full output register that is not drained holds the frame in the
// input register. One frame is taken every cycle as long as the output side
// keeps up. cfg_index 0 sets frames_to_confirm (reset 3), 1 sets
// holdover_frames (reset 5); write them only while no frame is in flight.
// The echoed needed_frames is the value at the time the frame is evaluated.
module detection_confirm_holdover_filter (
  input  logic                clk,
  input  logic                rst_n,
  // frame input
  input  logic                in_valid,
  output logic                in_ready,
  input  dchf_pkg::in_item_t  in_data,
  // tracking result
  output logic                out_valid,
  input  logic                out_ready,
  output dchf_pkg::out_item_t out_data,
  // configuration writes
  input  logic                cfg_we,
  input  logic [0:0]          cfg_index,
  input  logic [7:0]          cfg_wdata
);

  dchf_pkg::cfg_t      cfg_r;
  logic                in_vld_r;
  dchf_pkg::in_item_t  in_data_r;
  logic                out_vld_r;
  dchf_pkg::out_item_t out_data_r;
  dchf_pkg::out_item_t result;
  logic                advance;

  // A frame moves from the input register into the slot/output stage whenever
  // the output register is empty or being drained this cycle.
  assign advance  = in_vld_r && (!out_vld_r || out_ready);
  assign in_ready = !in_vld_r || advance;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.frames_to_confirm <= 8'd3;
      cfg_r.holdover_frames   <= 8'd5;
    end else if (cfg_we) begin
      unique case (dchf_pkg::cfg_index_t'(cfg_index))
        dchf_pkg::CFG_FRAMES_TO_CONFIRM: cfg_r.frames_to_confirm <= cfg_wdata;
        dchf_pkg::CFG_HOLDOVER_FRAMES:   cfg_r.holdover_frames   <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_ready) begin
      in_vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      in_data_r <= in_data;
    end
  end

  // Tracked slot and per-frame decision
  dchf_slot u_slot (
    .clk     (clk),
    .rst_n   (rst_n),
    .advance (advance),
    .item    (in_data_r),
    .cfg     (cfg_r),
    .result  (result)
  );

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (advance) begin
      out_vld_r <= 1'b1;
    end else if (out_ready) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_data_r <= result;
    end
  end

  assign out_valid = out_vld_r;
  assign out_data  = out_data_r;

endmodule

[tb/testbench.sv]
`timescale 1ns / 100ps

// Tracks the expected state of the single sign slot and holds the results
// still owed by the block, oldest first.
class track_scoreboard;
  logic [7:0]  need_frames;
  logic [7:0]  hold_frames;
  logic        slot_valid;
  logic        slot_conf;
  logic [7:0]  slot_sign;
  logic [7:0]  slot_label;
  logic [15:0] slot_run;
  logic [31:0] slot_conf_ms;
  logic [31:0] slot_seen_ms;
  logic [8:0]  misses;
  dchf_pkg::out_item_t due_q[$];
  int          errors;

  function new();
    need_frames = 8'd3;
    hold_frames = 8'd5;
    errors = 0;
    clear_slot();
  endfunction

  function void clear_slot();
    slot_valid = 1'b0;
    slot_conf = 1'b0;
    slot_sign = '0;
    slot_label = '0;
    slot_run = '0;
    slot_conf_ms = '0;
    slot_seen_ms = '0;
    misses = '0;
  endfunction

  function void set_reg(dchf_pkg::cfg_index_t idx, logic [7:0] value);
    if (idx == dchf_pkg::CFG_FRAMES_TO_CONFIRM) begin
      need_frames = value;
    end else begin
      hold_frames = value;
    end
  endfunction

  function int pending();
    return due_q.size();
  endfunction

  // tracked fields are shown only for candidate / confirmed with a live slot
  function dchf_pkg::out_item_t report(dchf_pkg::track_status_t st);
    dchf_pkg::out_item_t r;
    logic show;
    show = (st == dchf_pkg::TRK_CANDIDATE || st == dchf_pkg::TRK_CONFIRMED) && slot_valid;
    r = '0;
    r.track_status = st;
    r.needed_frames = need_frames;
    if (show) begin
      r.tracked_sign = slot_sign;
      r.tracked_label = slot_label;
      r.run_length = slot_run;
      r.seen_time_ms = slot_seen_ms;
      if (slot_conf) r.confirm_time_ms = slot_conf_ms;
    end
    return r;
  endfunction

  // one accepted frame request -> one expected result
  function void log_frame(dchf_pkg::in_item_t f);
    dchf_pkg::track_status_t st;
    logic          same;
    logic [15:0]   nxt;
    logic [15:0]   need_w;
    need_w = {8'h00, need_frames};
    if (f.frame_status != dchf_pkg::FRM_RUNNING) begin
      clear_slot();
      if (f.frame_status == dchf_pkg::FRM_DISABLED) st = dchf_pkg::TRK_DISABLED;
      else st = dchf_pkg::TRK_ERROR;
    end else if (!f.has_detection) begin
      if (misses != dchf_pkg::MISS_MAX) misses = misses + 9'd1;
      if (!(slot_valid && misses <= {1'b0, hold_frames})) clear_slot();
      if (!slot_valid) st = dchf_pkg::TRK_IDLE;
      else if (slot_conf) st = dchf_pkg::TRK_CONFIRMED;
      else st = dchf_pkg::TRK_CANDIDATE;
    end else begin
      same = slot_valid && slot_sign == f.sign_code && slot_label == f.label_code;
      misses = '0;
      if (same) begin
        nxt = (slot_run == dchf_pkg::RUN_MAX) ? dchf_pkg::RUN_MAX : slot_run + 16'd1;
        slot_seen_ms = f.frame_time_ms;
        if (slot_conf) begin
          slot_run = (nxt < need_w) ? need_w : nxt;
        end else begin
          slot_run = nxt;
          if (nxt >= need_w) begin
            slot_conf = 1'b1;
            slot_conf_ms = f.frame_time_ms;
          end
        end
      end else begin
        clear_slot();
        slot_valid = 1'b1;
        slot_sign = f.sign_code;
        slot_label = f.label_code;
        slot_seen_ms = f.frame_time_ms;
        if (need_frames <= 8'd1) begin
          slot_conf = 1'b1;
          slot_run = need_w;
          slot_conf_ms = f.frame_time_ms;
        end else begin
          slot_run = 16'd1;
        end
      end
      if (slot_conf) st = dchf_pkg::TRK_CONFIRMED;
      else st = dchf_pkg::TRK_CANDIDATE;
    end
    due_q.push_back(report(st));
  endfunction

  function void check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      errors++;
      if (errors <= 20)
        $display("%0t: %s expected %0h actual %0h", $time, name, want, got);
    end
  endfunction

  function void check_track(dchf_pkg::out_item_t got);
    dchf_pkg::out_item_t want;
    if (due_q.size() == 0) begin
      errors++;
      if (errors <= 20)
        $display("%0t: result expected none actual %p", $time, got);
      return;
    end
    want = due_q.pop_front();
    check_field("track_status", 32'(want.track_status), 32'(got.track_status));
    check_field("tracked_sign", 32'(want.tracked_sign), 32'(got.tracked_sign));
    check_field("tracked_label", 32'(want.tracked_label), 32'(got.tracked_label));
    check_field("run_length", 32'(want.run_length), 32'(got.run_length));
    check_field("needed_frames", 32'(want.needed_frames), 32'(got.needed_frames));
    check_field("confirm_time_ms", want.confirm_time_ms, got.confirm_time_ms);
    check_field("seen_time_ms", want.seen_time_ms, got.seen_time_ms);
  endfunction
endclass

module testbench;

  // cycles with no request moving on either side before the run is abandoned;
  // well above the longest receiver hold-off
  localparam int WATCHDOG_LIMIT = 2000;
  // receiver hold-off long enough to back the block up into the sender
  localparam int HOLD_OFF_CYCLES = 300;

  logic       clk;
  logic       rst_n;
  logic       in_valid;
  logic       in_ready;
  dchf_pkg::in_item_t  in_data;
  logic       out_valid;
  logic       out_ready;
  dchf_pkg::out_item_t out_data;
  logic       cfg_we;
  logic [0:0] cfg_index;
  logic [7:0] cfg_wdata;

  track_scoreboard board = new();

  logic [31:0] stamp_ms;     // running frame timestamp
  int          burst_left;   // frames left in the current sender burst
  int          frames_sent;  // accepted frame requests

  detection_confirm_holdover_filter u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Offer one frame request and hold it until taken. Bursts of random length
  // are separated by random gaps; a gap of zero just chains the bursts.
  // Handshake signals are sampled right after the edge, before any NBA lands.
  task automatic send_frame(input dchf_pkg::in_item_t f);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300)
                                               : $urandom_range(1, 30);
    end
    burst_left--;
    in_valid <= 1'b1;
    in_data <= f;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    board.log_frame(f);
    frames_sent++;
  endtask

  // build a frame at the running timestamp, then advance the timestamp
  task automatic frame(input dchf_pkg::frame_status_t st, input logic has,
                       input logic [7:0] sign, input logic [7:0] label);
    dchf_pkg::in_item_t f;
    f.frame_status = st;
    f.has_detection = has;
    f.sign_code = sign;
    f.label_code = label;
    f.frame_time_ms = stamp_ms;
    send_frame(f);
    stamp_ms = stamp_ms + $urandom_range(1, 200);
  endtask

  // one register write, followed by cfg_we low so writes never abut
  task automatic write_reg(input dchf_pkg::cfg_index_t idx, input logic [7:0] value);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    @(posedge clk);
    board.set_reg(idx, value);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // Drain: stop offering, wait for every owed result, then give the pipe
  // (two register stages) some slack before touching the registers.
  task automatic configure(input logic [7:0] need, input logic [7:0] hold);
    in_valid <= 1'b0;
    burst_left = 0;
    while (board.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    write_reg(dchf_pkg::CFG_FRAMES_TO_CONFIRM, need);
    write_reg(dchf_pkg::CFG_HOLDOVER_FRAMES, hold);
  endtask

  // Random phase under one setting. Mostly well-formed episodes: a run of
  // matching frames, sometimes long enough to confirm, then a run of empty
  // frames, sometimes long enough to drop the slot. The rest is label/sign
  // mismatches, detector faults and pure noise.
  task automatic track_phase(input logic [7:0] need, input logic [7:0] hold,
                             input int budget);
    logic [7:0] pool_sign[3];
    logic [7:0] pool_label[3];
    int         start, kind, p, k, e;
    configure(need, hold);
    for (int i = 0; i < 3; i++) begin
      pool_sign[i] = 8'($urandom);
      pool_label[i] = 8'($urandom);
    end
    start = frames_sent;
    while (frames_sent - start < budget) begin
      kind = $urandom_range(0, 9);
      p = $urandom_range(0, 2);
      if (kind <= 5) begin
        k = ($urandom_range(0, 3) == 0) ? int'(need) + $urandom_range(0, 3)
                                        : $urandom_range(1, 6);
        e = ($urandom_range(0, 3) == 0) ? int'(hold) + $urandom_range(0, 2)
                                        : $urandom_range(0, 3);
        repeat (k) frame(dchf_pkg::FRM_RUNNING, 1'b1, pool_sign[p], pool_label[p]);
        repeat (e) frame(dchf_pkg::FRM_RUNNING, 1'b0, 8'($urandom), 8'($urandom));
      end else if (kind == 6) begin
        // same sign, other label; or a different sign, same label
        if ($urandom_range(0, 1) == 0)
          frame(dchf_pkg::FRM_RUNNING, 1'b1, pool_sign[p],
                pool_label[p] ^ 8'($urandom_range(1, 255)));
        else
          frame(dchf_pkg::FRM_RUNNING, 1'b1, pool_sign[p] ^ 8'($urandom_range(1, 255)),
                pool_label[p]);
      end else if (kind == 7) begin
        frame(dchf_pkg::frame_status_t'($urandom_range(1, 3)), 1'($urandom_range(0, 1)),
              8'($urandom), 8'($urandom));
      end else begin
        // noise: any status, any flag, a jump to an arbitrary timestamp
        stamp_ms = $urandom;
        frame(dchf_pkg::frame_status_t'($urandom_range(0, 3)), 1'($urandom_range(0, 1)),
              8'($urandom), 8'($urandom));
      end
    end
  endtask

  // Result side: accepted results are checked against the oldest expectation.
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) board.check_track(out_data);
  end

  // Receiver: stretches of always-ready, coin-flip, one-in-three and
  // mostly-ready, with a long hold-off every eighth stretch so the block fills
  // and pushes back on the sender.
  initial begin : receiver
    int seg, mode, len;
    out_ready = 1'b0;
    seg = 0;
    while (rst_n !== 1'b1) @(posedge clk);
    forever begin
      seg++;
      if (seg % 8 == 4) begin
        out_ready <= 1'b0;
        repeat (HOLD_OFF_CYCLES) @(posedge clk);
      end else begin
        mode = $urandom_range(0, 3);
        len = $urandom_range(20, 200);
        for (int i = 0; i < len; i++) begin
          case (mode)
            0: begin
              out_ready <= 1'b1;
            end
            1: begin
              out_ready <= 1'($urandom_range(0, 1));
            end
            2: begin
              out_ready <= (i % 3 == 0);
            end
            default: begin
              out_ready <= ($urandom_range(0, 7) != 0);
            end
          endcase
          @(posedge clk);
        end
      end
    end
  end

  // Watchdog: gives up when no request moves on either side for too long.
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready)) quiet = 0;
      else quiet++;
    end
    $display("simulation failed");
    $finish;
  end

  initial begin : stimulus
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    cfg_we = 1'b0;
    cfg_index = dchf_pkg::CFG_FRAMES_TO_CONFIRM;
    cfg_wdata = '0;
    stamp_ms = 32'd1000;
    burst_left = 0;
    frames_sent = 0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // --- directed, reset settings (confirm after 3, hold 5) ---
    frame(dchf_pkg::FRM_RUNNING, 1'b0, 8'h00, 8'h00);             // empty while idle
    repeat (3) frame(dchf_pkg::FRM_RUNNING, 1'b1, 8'h5A, 8'hA5);  // cand, cand, confirm
    frame(dchf_pkg::FRM_RUNNING, 1'b1, 8'h5A, 8'hA5);             // confirmed, run grows
    repeat (6) frame(dchf_pkg::FRM_RUNNING, 1'b0, 8'h5A, 8'hA5);  // held 5, dropped on 6th
    stamp_ms = 32'hFFFF_FFFF;
    frame(dchf_pkg::FRM_RUNNING, 1'b1, 8'hFF, 8'hFF);             // field extremes
    frame(dchf_pkg::FRM_RUNNING, 1'b1, 8'hFF, 8'h00);             // same sign, other label
    stamp_ms = 32'h0000_0000;
    frame(dchf_pkg::FRM_RUNNING, 1'b1, 8'h00, 8'h00);
    frame(dchf_pkg::FRM_DISABLED, 1'b1, 8'h00, 8'h00);
    frame(dchf_pkg::FRM_ERROR, 1'b1, 8'h12, 8'h34);
    frame(dchf_pkg::FRM_UNUSED, 1'b0, 8'h56, 8'h78);              // unused code -> error

    // no confirmation needed: run_length 0 at once, no holdover at all
    configure(8'd0, 8'd0);
    repeat (2) frame(dchf_pkg::FRM_RUNNING, 1'b1, 8'h3C, 8'hC3);
    frame(dchf_pkg::FRM_RUNNING, 1'b0, 8'h3C, 8'hC3);

    // single frame confirms; slot survives into the next setting
    configure(8'd1, 8'd0);
    repeat (2) frame(dchf_pkg::FRM_RUNNING, 1'b1, 8'h81, 8'h18);

    // raised threshold lifts a confirmed run up to it; then a fresh candidate
    configure(8'd255, 8'd255);
    frame(dchf_pkg::FRM_RUNNING, 1'b1, 8'h81, 8'h18);
    frame(dchf_pkg::FRM_RUNNING, 1'b1, 8'h7E, 8'hE7);
    frame(dchf_pkg::FRM_RUNNING, 1'b0, 8'h00, 8'h00);

    // --- random phases over several settings ---
    track_phase(8'd3, 8'd5, 180);
    track_phase(8'd0, 8'd0, 180);
    track_phase(8'd1, 8'd1, 180);
    track_phase(8'd2, 8'd3, 180);
    track_phase(8'd255, 8'd255, 180);
    track_phase(8'($urandom_range(0, 255)), 8'($urandom_range(0, 8)), 180);
    track_phase(8'd4, 8'd0, 180);
    track_phase(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)), 180);

    in_valid <= 1'b0;
    while (board.pending() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (board.errors == 0 && board.pending() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

[filelist.f]
rtl/dchf_pkg.sv
rtl/dchf_slot.sv
rtl/detection_confirm_holdover_filter.sv
tb/testbench.sv
